// ----- sv/lcdw_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared widths, constants and the digit segment table of the two-digit
// segment LCD writer.
// ----------------------------------------------------------------------------
package lcdw_pkg;

    // payload widths
    localparam int NUMBER_W = 31;
    localparam int POS_W    = 3;
    localparam int IDX_W    = 5;
    localparam int VAL_W    = 8;

    // shadow of the lcd data registers: four rows of five bytes
    localparam int SHADOW_BYTES = 20;
    localparam int ROW_STRIDE   = 5;

    // default number of digit positions on the glass
    localparam int NUM_POSITIONS_DEF = 6;

    // floor(n / 100) = (n * RECIP_M) >> RECIP_SHIFT for every 31-bit n
    localparam int                    RECIP_SHIFT = 37;
    localparam logic [NUMBER_W-1:0]   RECIP_M     = 31'd1374389535;
    localparam int                    QUOT_W      = 25;
    localparam int                    PROD_W      = 2 * NUMBER_W;

    // nibble masks for read-modify-write
    localparam logic [VAL_W-1:0] KEEP_ODD  = 8'h0f;
    localparam logic [VAL_W-1:0] KEEP_EVEN = 8'hf0;

    // last step index of a job with one or two digits
    localparam logic [2:0] STEP_LAST_ONE = 3'd3;
    localparam logic [2:0] STEP_LAST_TWO = 3'd7;

    typedef logic [3:0]          t_digit;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [15:0]         t_pattern;

    // segment pattern of one decimal digit, lowest nibble is row 0
    function automatic t_pattern seg_pattern(input t_digit d);
        t_pattern p;
        case (d)
            4'd0:    p = 16'h1551;
            4'd1:    p = 16'h0118;
            4'd2:    p = 16'h1e11;
            4'd3:    p = 16'h1b11;
            4'd4:    p = 16'h0b50;
            4'd5:    p = 16'h1b41;
            4'd6:    p = 16'h1f41;
            4'd7:    p = 16'h4009;
            4'd8:    p = 16'h1f51;
            4'd9:    p = 16'h1b51;
            default: p = 16'h0000;
        endcase
        return p;
    endfunction

endpackage

// ----- sv/lcdw_if.sv -----
// ----------------------------------------------------------------------------
// lcdw_if
// Valid/ready channels of the two-digit segment LCD writer: the number
// channel in and the register write channel out.
// ----------------------------------------------------------------------------
interface lcdw_in_if;
    logic                          valid;
    logic                          ready;
    logic [lcdw_pkg::NUMBER_W-1:0] number;
    logic [lcdw_pkg::POS_W-1:0]    start_pos;

    modport source (output valid, number, start_pos, input ready);
    modport sink   (input valid, number, start_pos, output ready);
endinterface

interface lcdw_out_if;
    logic                       valid;
    logic                       ready;
    logic [lcdw_pkg::IDX_W-1:0] reg_index;
    logic [lcdw_pkg::VAL_W-1:0] reg_value;
    logic                       last;

    modport source (output valid, reg_index, reg_value, last, input ready);
    modport sink   (input valid, reg_index, reg_value, last, output ready);
endinterface

// ----- sv/lcd_two_digit_writer.sv -----
// ----------------------------------------------------------------------------
// lcd_two_digit_writer
// Shows the last two decimal digits of a number on a segment LCD by
// writing its data registers through a 20-byte shadow.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries a number and the position of its tens digit. The units
//   digit goes to the next position. o_out carries one register write per
//   item: register index, new full byte value, and last on the final write
//   of the input item. A full item gives 8 writes, an item whose units digit
//   falls off the glass gives 4, an item with start_pos at or beyond
//   NUM_POSITIONS gives none.
//   Path of an item: stage 1 register, divide-by-100 multiply into stage 2,
//   remainder into stage 3, digit split into the job register, write step
//   into the output register, which then holds the item's first write.
//   Throughput: one register write per cycle while o_out.ready is high, set
//   by the write sequencer with its single shadow port. Up to four items are
//   held in the pipeline, so items are taken while earlier writes go out.
//   Reset clears all pipeline valid bits and the whole shadow to zero.
//   When the receiver holds o_out.ready low the write stays on the port
//   unchanged, the sequencer waits and the pipeline fills, then i_in.ready
//   drops.
// ----------------------------------------------------------------------------
module lcd_two_digit_writer #(
    parameter int NUM_POSITIONS = lcdw_pkg::NUM_POSITIONS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lcdw_in_if.sink          i_in,
    lcdw_out_if.source       o_out
);

    localparam logic [lcdw_pkg::POS_W:0] NPOS = (lcdw_pkg::POS_W + 1)'(NUM_POSITIONS);

    // stage 1: accepted item
    logic                            r_s1_vld;
    logic [lcdw_pkg::NUMBER_W-1:0]   r_s1_num;
    lcdw_pkg::t_pos                  r_s1_pos;

    // stage 2: quotient by 100
    logic                            r_s2_vld;
    logic [lcdw_pkg::QUOT_W-1:0]     r_s2_q;
    logic [6:0]                      r_s2_lo7;
    lcdw_pkg::t_pos                  r_s2_pos;

    // stage 3: number mod 100
    logic                            r_s3_vld;
    logic [6:0]                      r_s3_low2;
    lcdw_pkg::t_pos                  r_s3_pos;

    // job register of the write sequencer
    logic                            r_job_vld;
    lcdw_pkg::t_digit                r_job_tens;
    lcdw_pkg::t_digit                r_job_units;
    lcdw_pkg::t_pos                  r_job_pos;
    logic                            r_job_any;
    logic [2:0]                      r_job_last_step;
    logic [2:0]                      r_cnt;

    // output register
    logic                            r_out_vld;
    logic [lcdw_pkg::IDX_W-1:0]      r_out_idx;
    logic [lcdw_pkg::VAL_W-1:0]      r_out_val;
    logic                            r_out_last;

    logic [lcdw_pkg::VAL_W-1:0]      r_shadow [lcdw_pkg::SHADOW_BYTES];

    logic                            w_s1_rdy, w_s2_rdy, w_s3_rdy, w_job_rdy;
    logic [lcdw_pkg::PROD_W-1:0]     w_prod;
    logic [13:0]                     w_q100;
    logic [6:0]                      w_low2;
    lcdw_pkg::t_digit                w_tens;
    logic [6:0]                      w_units7;
    logic [lcdw_pkg::POS_W:0]        w_pos_ext;
    logic                            w_out_free, w_emit, w_step_last, w_job_done;
    lcdw_pkg::t_digit                w_step_digit;
    lcdw_pkg::t_pos                  w_step_pos;
    logic [1:0]                      w_row;
    lcdw_pkg::t_pattern              w_pattern, w_shifted;
    logic [3:0]                      w_nib;
    logic [lcdw_pkg::IDX_W-1:0]      w_idx;
    logic [lcdw_pkg::VAL_W-1:0]      w_old, w_new;

    // pipeline handshake
    assign w_out_free = !r_out_vld || o_out.ready;
    assign w_job_rdy  = !r_job_vld || w_job_done;
    assign w_s3_rdy   = !r_s3_vld || w_job_rdy;
    assign w_s2_rdy   = !r_s2_vld || w_s3_rdy;
    assign w_s1_rdy   = !r_s1_vld || w_s2_rdy;
    assign i_in.ready = w_s1_rdy;

    // quotient by reciprocal multiply
    assign w_prod = lcdw_pkg::PROD_W'(r_s1_num) * lcdw_pkg::PROD_W'(lcdw_pkg::RECIP_M);

    // remainder: only the low seven bits matter since it stays below 100
    assign w_q100 = r_s2_q[6:0] * 7'd100;
    assign w_low2 = r_s2_lo7 - w_q100[6:0];

    // tens digit by threshold compares, units by subtraction
    always_comb begin
        w_tens = '0;
        for (int k = 1; k <= 9; k++) begin
            if (r_s3_low2 >= 7'(10 * k)) begin
                w_tens = 4'(k);
            end
        end
    end
    assign w_units7  = r_s3_low2 - ({w_tens, 3'b000} + {2'b00, w_tens, 1'b0});
    assign w_pos_ext = {1'b0, r_s3_pos};

    // current write step
    assign w_step_digit = r_cnt[2] ? r_job_units : r_job_tens;
    assign w_step_pos   = r_job_pos + lcdw_pkg::POS_W'(r_cnt[2]);
    assign w_row        = r_cnt[1:0];
    assign w_pattern    = lcdw_pkg::seg_pattern(w_step_digit);
    assign w_shifted    = w_pattern >> {w_row, 2'b00};
    assign w_nib        = w_shifted[3:0];
    assign w_idx        = {3'b000, w_step_pos[2:1]} + {1'b0, w_row, 2'b00}
                        + {3'b000, w_row};
    assign w_old        = r_shadow[w_idx];
    assign w_new        = w_step_pos[0] ? ((w_old & lcdw_pkg::KEEP_ODD) | {w_nib, 4'h0})
                                        : ((w_old & lcdw_pkg::KEEP_EVEN) | {4'h0, w_nib});
    assign w_step_last  = (r_cnt == r_job_last_step);
    assign w_emit       = r_job_vld && r_job_any && w_out_free;
    assign w_job_done   = r_job_vld && (!r_job_any || (w_emit && w_step_last));

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_job_vld <= 1'b0;
        end else begin
            if (w_s1_rdy)  r_s1_vld  <= i_in.valid;
            if (w_s2_rdy)  r_s2_vld  <= r_s1_vld;
            if (w_s3_rdy)  r_s3_vld  <= r_s2_vld;
            if (w_job_rdy) r_job_vld <= r_s3_vld;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_s1_rdy) begin
            r_s1_num <= i_in.number;
            r_s1_pos <= i_in.start_pos;
        end
        if (w_s2_rdy) begin
            r_s2_q   <= w_prod[lcdw_pkg::PROD_W-1:lcdw_pkg::RECIP_SHIFT];
            r_s2_lo7 <= r_s1_num[6:0];
            r_s2_pos <= r_s1_pos;
        end
        if (w_s3_rdy) begin
            r_s3_low2 <= w_low2;
            r_s3_pos  <= r_s2_pos;
        end
        if (w_job_rdy) begin
            r_job_tens      <= w_tens;
            r_job_units     <= w_units7[3:0];
            r_job_pos       <= r_s3_pos;
            r_job_any       <= (w_pos_ext < NPOS);
            r_job_last_step <= ((w_pos_ext + 1'b1) < NPOS) ? lcdw_pkg::STEP_LAST_TWO
                                                           : lcdw_pkg::STEP_LAST_ONE;
        end
    end

    // write step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_job_done) begin
            r_cnt <= '0;
        end else if (w_emit) begin
            r_cnt <= r_cnt + 3'd1;
        end
    end

    // shadow read-modify-write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lcdw_pkg::SHADOW_BYTES; i++) begin
                r_shadow[i] <= '0;
            end
        end else if (w_emit) begin
            r_shadow[w_idx] <= w_new;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_emit) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_idx  <= w_idx;
            r_out_val  <= w_new;
            r_out_last <= w_step_last;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.reg_index = r_out_idx;
    assign o_out.reg_value = r_out_val;
    assign o_out.last      = r_out_last;

    // checks
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_idx < lcdw_pkg::IDX_W'(lcdw_pkg::SHADOW_BYTES)))
        else $error("register index beyond shadow");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_job_vld |-> (r_cnt == 3'd0))
        else $error("step counter running without a job");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_vld |-> (r_cnt <= r_job_last_step))
        else $error("step counter past last step");

    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_step_last) |=> (r_out_vld && r_out_last))
        else $error("final write not flagged last");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_vld && !r_job_vld && !r_s1_vld))
        else $error("pipeline not empty after reset");

endmodule

// ----- tb/sv/lcd_two_digit_writer_checker.sv -----
// ----------------------------------------------------------------------------
// lcd_two_digit_writer_checker
// Watches both channels of the two-digit LCD writer. It keeps its own copy of
// the segment register shadow, predicts the register writes of every accepted
// number and compares each accepted write with the oldest prediction.
// ----------------------------------------------------------------------------
module lcd_two_digit_writer_checker #(
    parameter int NUM_POSITIONS = lcdw_pkg::NUM_POSITIONS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lcdw_in_if   i_in,
    lcdw_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [lcdw_pkg::IDX_W-1:0] index;
        logic [lcdw_pkg::VAL_W-1:0] value;
        logic                       last;
    } t_reg_write;

    // segment patterns of digits 0..9, row 0 in the lowest nibble
    localparam logic [15:0] DIGIT_SEGMENTS [10] = '{
        16'h1551, 16'h0118, 16'h1e11, 16'h1b11, 16'h0b50,
        16'h1b41, 16'h1f41, 16'h4009, 16'h1f51, 16'h1b51
    };

    logic [lcdw_pkg::VAL_W-1:0] glass_shadow [lcdw_pkg::SHADOW_BYTES];
    t_reg_write                 expected_writes [$];
    int                         fail_count = 0;

    // one digit into its nibble column, four rows, read-modify-write
    function automatic void shadow_write_digit(input int unsigned digit,
                                               input int unsigned pos);
        logic [15:0]                pattern;
        logic [lcdw_pkg::VAL_W-1:0] keep;
        logic [lcdw_pkg::VAL_W-1:0] nib;
        int unsigned                idx;
        t_reg_write                 wr;
        if (pos >= NUM_POSITIONS) return;
        pattern = DIGIT_SEGMENTS[digit];
        keep    = pos[0] ? lcdw_pkg::KEEP_ODD : lcdw_pkg::KEEP_EVEN;
        for (int row = 0; row < 4; row++) begin
            idx = (pos >> 1) + row * lcdw_pkg::ROW_STRIDE;
            nib = {4'h0, pattern[4*row +: 4]};
            if (pos[0]) nib = nib << 4;
            if (idx < lcdw_pkg::SHADOW_BYTES) begin
                glass_shadow[idx] = (glass_shadow[idx] & keep) | nib;
                wr.index = idx[lcdw_pkg::IDX_W-1:0];
                wr.value = glass_shadow[idx];
                wr.last  = 1'b0;
                expected_writes.push_back(wr);
            end
        end
    endfunction

    // tens digit at start_pos, units at the next position, last on the final write
    function automatic void predict_number_writes(
        input logic [lcdw_pkg::NUMBER_W-1:0] number,
        input logic [lcdw_pkg::POS_W-1:0]    start_pos);
        int unsigned low2;
        int          prior_count;
        low2        = int'(number) % 100;
        prior_count = expected_writes.size();
        shadow_write_digit(low2 / 10, start_pos);
        shadow_write_digit(low2 % 10, start_pos + 1);
        if (expected_writes.size() > prior_count)
            expected_writes[expected_writes.size() - 1].last = 1'b1;
    endfunction

    // compare accepted writes, then predict from accepted numbers
    always @(posedge i_clk) begin
        t_reg_write want;
        if (!i_rst_n) begin
            foreach (glass_shadow[i]) glass_shadow[i] = '0;
            expected_writes.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (expected_writes.size() == 0) begin
                    $error("unexpected write: reg_index %0d reg_value 0x%02h last %0b",
                           i_out.reg_index, i_out.reg_value, i_out.last);
                    fail_count++;
                end else begin
                    want = expected_writes.pop_front();
                    if (i_out.reg_index !== want.index) begin
                        $error("reg_index: expected %0d, got %0d",
                               want.index, i_out.reg_index);
                        fail_count++;
                    end
                    if (i_out.reg_value !== want.value) begin
                        $error("reg_value: expected 0x%02h, got 0x%02h",
                               want.value, i_out.reg_value);
                        fail_count++;
                    end
                    if (i_out.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_out.last);
                        fail_count++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                predict_number_writes(i_in.number, i_in.start_pos);
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_writes.size();
    end

endmodule

// ----- tb/sv/lcd_two_digit_writer_test.sv -----
// ----------------------------------------------------------------------------
// lcd_two_digit_writer_test
// Drives numbers and start positions into the two-digit LCD writer with
// random gaps and random write back-pressure, including one long stall of the
// write channel and two full drains, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module lcd_two_digit_writer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS     = 310;
    localparam int LONG_HOLD_AT     = 400;
    localparam int LONG_HOLD_CYCLES = 100;
    localparam int TAIL_CYCLES      = 16;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   items_sent = 0;

    lcdw_in_if  in_ch ();
    lcdw_out_if out_ch ();

    lcd_two_digit_writer u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    lcd_two_digit_writer_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // hard stop
    initial begin
        #2_000_000;
        $display("[lcd_two_digit_writer] ERROR");
        $finish;
    end

    // offer one item after a random gap, hold it until taken
    task automatic send_number(input logic [lcdw_pkg::NUMBER_W-1:0] number,
                               input lcdw_pkg::t_pos start_pos);
        int unsigned gap;
        gap = ((items_sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.number    <= number;
        in_ch.start_pos <= start_pos;
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // stop offering until every predicted write has come out
    task automatic wait_writes_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // write channel receiver with random stalls and one long hold-off
    initial begin
        int unsigned hold;
        int          writes_taken;
        writes_taken = 0;
        out_ch.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (writes_taken == LONG_HOLD_AT)
                hold = LONG_HOLD_CYCLES;
            else if ((writes_taken / 64) % 3 == 1)
                hold = 0;
            else
                hold = $urandom_range(0, 3);
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
            writes_taken++;
        end
    end

    // stimulus
    initial begin
        logic [lcdw_pkg::NUMBER_W-1:0] number;
        lcdw_pkg::t_pos                start_pos;
        int                            useful;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.number    <= '0;
        in_ch.start_pos <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every digit as tens and units, all positions, field extremes
        send_number(31'd0, 3'd0);
        send_number(31'd2147483647, 3'd0);
        send_number(31'd12, 3'd1);
        send_number(31'd34, 3'd2);
        send_number(31'd56, 3'd3);
        send_number(31'd78, 3'd4);
        // units digit falls off the glass
        send_number(31'd90, 3'd5);
        send_number(31'd65, 3'd0);
        send_number(31'd89, 3'd2);
        send_number(31'd23, 3'd4);
        send_number(31'd1000000001, 3'd1);
        send_number(31'd100, 3'd3);
        send_number(31'd99, 3'd5);
        // both digits off the glass
        send_number(31'd5, 3'd6);
        send_number(31'd2147483647, 3'd7);
        send_number(31'd73, 3'd5);
        send_number(31'd1073741824, 3'd2);
        send_number(31'd2147483600, 3'd4);
        wait_writes_drained();

        // random: mostly on-glass positions, mixed number magnitudes
        useful = 0;
        while (useful < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0, 1:    number = lcdw_pkg::NUMBER_W'($urandom_range(0, 99));
                2:       number = lcdw_pkg::NUMBER_W'($urandom() >> 1);
                default: number = lcdw_pkg::NUMBER_W'(32'd2147483647
                                                      - $urandom_range(0, 199));
            endcase
            if ($urandom_range(0, 99) < 12)
                start_pos = lcdw_pkg::POS_W'($urandom_range(6, 7));
            else
                start_pos = lcdw_pkg::POS_W'($urandom_range(0, 5));
            send_number(number, start_pos);
            if (start_pos < lcdw_pkg::NUM_POSITIONS_DEF) useful++;
        end

        // end of run
        wait_writes_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[lcd_two_digit_writer] OK");
        else
            $display("[lcd_two_digit_writer] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/lcdw_pkg.sv
sv/lcdw_if.sv
sv/lcd_two_digit_writer.sv
tb/sv/lcd_two_digit_writer_checker.sv
tb/sv/lcd_two_digit_writer_test.sv
